### rtl/core/stereo_point_triangulation_defines.svh
// Assertion macros shared by the triangulation RTL.
`ifndef STEREO_POINT_TRIANGULATION_DEFINES_SVH
`define STEREO_POINT_TRIANGULATION_DEFINES_SVH
`ifndef SYNTH
`define SPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SPT_ASSERT_IMPL(label, ante, cons)
`define SPT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/spt_pkg.sv
// Shared constants and types for the stereo triangulation pipeline.
package spt_pkg;

  localparam int NUM_W     = 98;
  localparam int DIV_STEPS = 32;

  localparam logic [2:0] REG_FOCAL   = 3'd0;
  localparam logic [2:0] REG_PP      = 3'd1;
  localparam logic [2:0] REG_R00_R01 = 3'd2;
  localparam logic [2:0] REG_R02_R10 = 3'd3;
  localparam logic [2:0] REG_R11_R12 = 3'd4;
  localparam logic [2:0] REG_R20_R21 = 3'd5;
  localparam logic [2:0] REG_R22_TX  = 3'd6;
  localparam logic [2:0] REG_T_YZ    = 3'd7;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [63:0]      dm;
  } div_in_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic        sat;
    logic [31:0] q;
  } div_out_t;

endpackage

### rtl/core/spt_div_lane.sv
// Pipelined restoring divider lane: one quotient bit per stage, saturated to 32 bits.
`include "stereo_point_triangulation_defines.svh"
module spt_div_lane (
  input  logic              clk,
  input  logic              rst,
  input  spt_pkg::div_in_t  din,
  output spt_pkg::div_out_t dout
);

  typedef struct packed {
    logic        ok;
    logic        zero;
    logic        neg;
    logic        dz;
    logic        big;
    logic [63:0] dm;
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } step_t;

  logic  vld [0:spt_pkg::DIV_STEPS];
  step_t st  [0:spt_pkg::DIV_STEPS];

  logic        out_vld;
  logic        out_ok;
  logic        out_sat;
  logic [31:0] out_q;

  // A quotient of 2^32 or more shows up when the upper part alone reaches the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    st[0].ok   <= din.ok;
    st[0].zero <= (din.num == '0);
    st[0].neg  <= din.neg;
    st[0].dz   <= (din.dm == 64'd0);
    st[0].big  <= (din.num[spt_pkg::NUM_W-1:32] >= {2'b00, din.dm});
    st[0].dm   <= din.dm;
    st[0].rem  <= din.num[95:32];
    st[0].low  <= din.num[31:0];
    st[0].q    <= 32'd0;
  end

  for (genvar i = 0; i < spt_pkg::DIV_STEPS; i++) begin : g_step
    logic [64:0] rsh;
    logic        ge;
    logic [64:0] diff;

    assign rsh  = {st[i].rem, st[i].low[31]};
    assign ge   = (rsh >= {1'b0, st[i].dm});
    assign diff = rsh - {1'b0, st[i].dm};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      st[i+1].ok   <= st[i].ok;
      st[i+1].zero <= st[i].zero;
      st[i+1].neg  <= st[i].neg;
      st[i+1].dz   <= st[i].dz;
      st[i+1].big  <= st[i].big;
      st[i+1].dm   <= st[i].dm;
      st[i+1].rem  <= ge ? diff[63:0] : rsh[63:0];
      st[i+1].low  <= {st[i].low[30:0], 1'b0};
      st[i+1].q    <= {st[i].q[30:0], ge};
    end
  end

  localparam int LAST = spt_pkg::DIV_STEPS;

  logic [31:0] lim;
  logic        over;

  assign lim  = st[LAST].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign over = st[LAST].dz || st[LAST].big || (st[LAST].q > lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    out_ok <= st[LAST].ok;
    if (st[LAST].zero) begin
      out_sat <= 1'b0;
      out_q   <= 32'd0;
    end else if (over) begin
      out_sat <= 1'b1;
      out_q   <= lim;
    end else begin
      out_sat <= 1'b0;
      out_q   <= st[LAST].neg ? (32'd0 - st[LAST].q) : st[LAST].q;
    end
  end

  assign dout = '{valid: out_vld, ok: out_ok, sat: out_sat, q: out_q};

  `SPT_ASSERT_IMPL(a_rem_bound, vld[LAST] && !st[LAST].dz && !st[LAST].big, st[LAST].rem < st[LAST].dm)
  `SPT_ASSERT_IMPL(a_sat_value, dout.valid && dout.sat, dout.q == 32'h7FFF_FFFF || dout.q == 32'h8000_0000)
  `SPT_ASSERT_NEXT(a_zero_result, vld[LAST] && st[LAST].zero, dout.q == 32'd0 && !dout.sat)

endmodule

### rtl/core/stereo_point_triangulation.sv
// Stereo point triangulation: one pixel pair in, one 3-D point out, every cycle.
// A request is taken whenever start is high and busy is low; busy is only high in the
// cycle after a reset cycle. The pipeline accepts one request per clock, and the result
// strobe done is high for exactly one cycle per result, with no way for the receiver
// to hold it. A request passes through nine stages of fixed-point products and sums,
// then one input stage, 32 quotient stages and one output stage in each of the
// three dividers. right_u takes no part in the result. Configuration is read directly
// by the pipeline and must only be written while no request is in flight.
`include "stereo_point_triangulation_defines.svh"
module stereo_point_triangulation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        left_u,
  input  logic [15:0]        left_v,
  input  logic [15:0]        right_u,
  input  logic [15:0]        right_v,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               depth_valid
);

  // Configuration registers (only the entries that the computation uses).
  logic [31:0]        fx, fy, cx, cy;
  logic signed [31:0] r10, r11, r12, r20, r21, r22, ty, tz;

  always_ff @(posedge clk) begin
    if (rst) begin
      fx <= '0; fy <= '0; cx <= '0; cy <= '0;
      r10 <= '0; r11 <= '0; r12 <= '0; r20 <= '0; r21 <= '0; r22 <= '0;
      ty <= '0; tz <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        spt_pkg::REG_FOCAL: begin
          fx <= cfg_data[63:32];
          fy <= cfg_data[31:0];
        end
        spt_pkg::REG_PP: begin
          cx <= cfg_data[63:32];
          cy <= cfg_data[31:0];
        end
        spt_pkg::REG_R02_R10: begin
          r10 <= cfg_data[31:0];
        end
        spt_pkg::REG_R11_R12: begin
          r11 <= cfg_data[63:32];
          r12 <= cfg_data[31:0];
        end
        spt_pkg::REG_R20_R21: begin
          r20 <= cfg_data[63:32];
          r21 <= cfg_data[31:0];
        end
        spt_pkg::REG_R22_TX: begin
          r22 <= cfg_data[63:32];
        end
        spt_pkg::REG_T_YZ: begin
          ty <= cfg_data[63:32];
          tz <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  function automatic logic [31:0] mag34(input logic signed [33:0] x);
    mag34 = x[33] ? 32'(-x) : x[31:0];
  endfunction

  // Valid bits.
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else begin
      v1 <= accept; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
    end
  end

  // Stage 1: offsets from the principal point, as sign and magnitude.
  logic signed [33:0] du_w, dv_w, e_w;
  logic               du_n1, dv_n1, e_n1;
  logic [31:0]        du_m1, dv_m1, e_m1;

  assign du_w = $signed({6'd0, left_u, 12'd0}) - $signed({2'd0, cx});
  assign dv_w = $signed({6'd0, left_v, 12'd0}) - $signed({2'd0, cy});
  assign e_w  = $signed({6'd0, right_v, 12'd0}) - $signed({2'd0, cy});

  always_ff @(posedge clk) begin
    du_n1 <= du_w[33]; du_m1 <= mag34(du_w);
    dv_n1 <= dv_w[33]; dv_m1 <= mag34(dv_w);
    e_n1  <= e_w[33];  e_m1  <= mag34(e_w);
  end

  // Stage 2: scaled ray N and the two products of the numerator.
  logic [63:0] p_du, p_dv, p_ff, p_ta, p_tb;
  logic [31:0] ty_m, tz_m;
  logic [47:0] nv_m2 [0:2];
  logic        nv_n2 [0:2];
  logic [47:0] ta_m2, tb_m2;
  logic        ta_n2, tb_n2, e_n2;
  logic [31:0] e_m2;

  assign ty_m = ty[31] ? 32'(-ty) : 32'(ty);
  assign tz_m = tz[31] ? 32'(-tz) : 32'(tz);
  assign p_du = du_m1 * fy;
  assign p_dv = dv_m1 * fx;
  assign p_ff = fx * fy;
  assign p_ta = fy * ty_m;
  assign p_tb = e_m1 * tz_m;

  always_ff @(posedge clk) begin
    nv_m2[0] <= p_du[63:16]; nv_n2[0] <= du_n1;
    nv_m2[1] <= p_dv[63:16]; nv_n2[1] <= dv_n1;
    nv_m2[2] <= p_ff[63:16]; nv_n2[2] <= 1'b0;
    ta_m2 <= p_ta[63:16]; ta_n2 <= ty[31];
    tb_m2 <= p_tb[63:16]; tb_n2 <= e_n1 ^ tz[31];
    e_n2 <= e_n1; e_m2 <= e_m1;
  end

  // Stage 3: numerator a, and partial products of R N (rows 1 and 2).
  logic signed [31:0] rot   [0:1][0:2];
  logic [31:0]        rot_m [0:1][0:2];
  logic [63:0]        pl_next [0:1][0:2];
  logic [47:0]        ph_next [0:1][0:2];
  logic signed [49:0] ta_v, tb_v;

  assign rot[0][0] = r10; assign rot[0][1] = r11; assign rot[0][2] = r12;
  assign rot[1][0] = r20; assign rot[1][1] = r21; assign rot[1][2] = r22;
  assign ta_v = ta_n2 ? -$signed({2'b00, ta_m2}) : $signed({2'b00, ta_m2});
  assign tb_v = tb_n2 ? -$signed({2'b00, tb_m2}) : $signed({2'b00, tb_m2});

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_m[i][j]   = rot[i][j][31] ? 32'(-rot[i][j]) : 32'(rot[i][j]);
        pl_next[i][j] = rot_m[i][j] * nv_m2[j][31:0];
        ph_next[i][j] = rot_m[i][j] * nv_m2[j][47:32];
      end
    end
  end

  logic [63:0]        pl3 [0:1][0:2];
  logic [47:0]        ph3 [0:1][0:2];
  logic               ps3 [0:1][0:2];
  logic signed [49:0] a3, a4, a5, a6, a7;
  logic [47:0]        nv_m3 [0:2], nv_m4 [0:2], nv_m5 [0:2], nv_m6 [0:2], nv_m7 [0:2];
  logic               nv_n3 [0:2], nv_n4 [0:2], nv_n5 [0:2], nv_n6 [0:2], nv_n7 [0:2];
  logic               e_n3, e_n4;
  logic [31:0]        e_m3, e_m4;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        pl3[i][j] <= pl_next[i][j];
        ph3[i][j] <= ph_next[i][j];
        ps3[i][j] <= rot[i][j][31] ^ nv_n2[j];
      end
    end
    a3 <= ta_v - tb_v;
    nv_m3 <= nv_m2; nv_n3 <= nv_n2;
    e_n3 <= e_n2; e_m3 <= e_m2;
  end

  // Stage 4: each term shifted by 30 toward zero, then the row sums M1 and M2.
  logic [79:0]        full4 [0:1][0:2];
  logic signed [50:0] term4 [0:1][0:2];
  logic signed [52:0] m_next [0:1];
  logic signed [52:0] m4 [0:1];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        full4[i][j] = {ph3[i][j], 32'd0} + {16'd0, pl3[i][j]};
        term4[i][j] = ps3[i][j] ? -$signed({1'b0, full4[i][j][79:30]})
                                :  $signed({1'b0, full4[i][j][79:30]});
      end
      m_next[i] = 53'(term4[i][0]) + 53'(term4[i][1]) + 53'(term4[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    m4 <= m_next;
    a4 <= a3;
    nv_m4 <= nv_m3; nv_n4 <= nv_n3;
    e_n4 <= e_n3; e_m4 <= e_m3;
  end

  // Stage 5: partial products of fy*M1 and e*M2.
  logic [52:0] m1_abs, m2_abs;
  logic [63:0] f_lo5, g_lo5;
  logic [51:0] f_hi5, g_hi5;
  logic        f_n5, g_n5;

  assign m1_abs = m4[0][52] ? 53'(-m4[0]) : 53'(m4[0]);
  assign m2_abs = m4[1][52] ? 53'(-m4[1]) : 53'(m4[1]);

  always_ff @(posedge clk) begin
    f_lo5 <= fy * m1_abs[31:0];
    f_hi5 <= fy * m1_abs[51:32];
    f_n5  <= m4[0][52];
    g_lo5 <= e_m4 * m2_abs[31:0];
    g_hi5 <= e_m4 * m2_abs[51:32];
    g_n5  <= e_n4 ^ m4[1][52];
    a5 <= a4;
    nv_m5 <= nv_m4; nv_n5 <= nv_n4;
  end

  // Stage 6: both terms shifted by 16 and held within the 64-bit range.
  logic [83:0]        f_full, g_full;
  logic               f_ovf, g_ovf;
  logic [62:0]        f_mag, g_mag;
  logic signed [63:0] tf6, te6;
  logic               sticky6;

  assign f_full = {f_hi5, 32'd0} + {20'd0, f_lo5};
  assign g_full = {g_hi5, 32'd0} + {20'd0, g_lo5};
  assign f_ovf  = |f_full[83:79];
  assign g_ovf  = |g_full[83:79];
  assign f_mag  = f_ovf ? {63{1'b1}} : f_full[78:16];
  assign g_mag  = g_ovf ? {63{1'b1}} : g_full[78:16];

  always_ff @(posedge clk) begin
    tf6 <= f_n5 ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
    te6 <= g_n5 ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
    sticky6 <= f_ovf || g_ovf;
    a6 <= a5;
    nv_m6 <= nv_m5; nv_n6 <= nv_n5;
  end

  // Stage 7: denominator b = e*M2 - fy*M1, saturating.
  logic signed [64:0] b_diff;
  logic               b_ovf;
  logic signed [63:0] b7;
  logic               sticky7;

  assign b_diff = $signed({te6[63], te6}) - $signed({tf6[63], tf6});
  assign b_ovf  = b_diff[64] != b_diff[63];

  always_ff @(posedge clk) begin
    if (b_ovf) begin
      b7 <= b_diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      b7 <= b_diff[63:0];
    end
    sticky7 <= sticky6 || b_ovf;
    a7 <= a6;
    nv_m7 <= nv_m6; nv_n7 <= nv_n6;
  end

  // Stage 8: partial products of a*N_k and the divisor magnitude.
  logic [49:0] a_abs;
  logic [63:0] ll8 [0:2];
  logic [47:0] lh8 [0:2];
  logic [48:0] hl8 [0:2];
  logic [32:0] hh8 [0:2];
  logic        neg8 [0:2];
  logic [63:0] dm8;
  logic        ok8;

  assign a_abs = a7[49] ? 50'(-a7) : 50'(a7);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ll8[k]  <= a_abs[31:0]  * nv_m7[k][31:0];
      lh8[k]  <= a_abs[31:0]  * nv_m7[k][47:32];
      hl8[k]  <= a_abs[48:32] * nv_m7[k][31:0];
      hh8[k]  <= a_abs[48:32] * nv_m7[k][47:32];
      neg8[k] <= a7[49] ^ nv_n7[k] ^ b7[63];
    end
    dm8 <= b7[63] ? 64'(-b7) : 64'(b7);
    ok8 <= !sticky7 && (b7 != 64'sd0);
  end

  // Stage 9: full products, which enter the divider lanes.
  logic [spt_pkg::NUM_W-1:0] num9 [0:2];
  logic                      neg9 [0:2];
  logic [63:0]               dm9;
  logic                      ok9;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num9[k] <= spt_pkg::NUM_W'(ll8[k])
               + (spt_pkg::NUM_W'(lh8[k]) << 32)
               + (spt_pkg::NUM_W'(hl8[k]) << 32)
               + (spt_pkg::NUM_W'(hh8[k]) << 64);
      neg9[k] <= neg8[k];
    end
    dm9 <= dm8;
    ok9 <= ok8;
  end

  spt_pkg::div_in_t  div_in   [0:2];
  spt_pkg::div_out_t lane_out [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign div_in[k] = '{valid: v9, ok: ok9, neg: neg9[k], num: num9[k], dm: dm9};

    spt_div_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .din  (div_in[k]),
      .dout (lane_out[k])
    );
  end

  assign done        = lane_out[0].valid;
  assign point_x     = lane_out[0].q;
  assign point_y     = lane_out[1].q;
  assign point_z     = lane_out[2].q;
  assign depth_valid = lane_out[0].ok && !lane_out[0].sat && !lane_out[1].sat
                       && !lane_out[2].sat;

  `SPT_ASSERT_IMPL(a_lanes_agree, lane_out[0].valid || lane_out[1].valid || lane_out[2].valid, lane_out[0].valid && lane_out[1].valid && lane_out[2].valid)
  `SPT_ASSERT_NEXT(a_flag_reaches_lanes, v8 && !ok8, div_in[0].valid && !div_in[2].ok)
  `SPT_ASSERT_NEXT(a_busy_clears, !rst, !busy)

endmodule

### verif/tb_stereo_point_triangulation.sv
// Self-checking testbench for the stereo point triangulation pipeline.
`timescale 1ns / 1ps
module tb_stereo_point_triangulation;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               ok;
  } point_t;

  localparam longint MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam longint MIN64 = 64'h8000_0000_0000_0000;

  class triangulation_book;
    logic [63:0] calib [8];
    point_t      awaited [$];
    bit          overflowed;
    bit          clipped;
    int          errors;

    function void set_reg(int idx, logic [63:0] val);
      calib[idx] = val;
    endfunction

    function longint hi_u(logic [63:0] r);
      return longint'({32'b0, r[63:32]});
    endfunction
    function longint lo_u(logic [63:0] r);
      return longint'({32'b0, r[31:0]});
    endfunction
    function longint hi_s(logic [63:0] r);
      return longint'({{32{r[63]}}, r[63:32]});
    endfunction
    function longint lo_s(logic [63:0] r);
      return longint'({{32{r[31]}}, r[31:0]});
    endfunction

    function logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Exact product shifted right, truncated toward zero, clamped to 64 bits.
    function longint mul_shift(longint x, longint y, int sh);
      logic [127:0] p;
      bit neg;
      neg = (x < 0) != (y < 0);
      p = {64'b0, magnitude(x)} * {64'b0, magnitude(y)};
      p = p >> sh;
      if (p[127:63] != 0) begin
        overflowed = 1;
        return neg ? -MAX64 : MAX64;
      end
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint add_sat(longint x, longint y);
      logic signed [64:0] s;
      s = {x[63], x} + {y[63], y};
      if (s[64] != s[63]) begin
        overflowed = 1;
        return s[64] ? MIN64 : MAX64;
      end
      return s[63:0];
    endfunction

    function longint sub_sat(longint x, longint y);
      logic signed [64:0] s;
      s = {x[63], x} - {y[63], y};
      if (s[64] != s[63]) begin
        overflowed = 1;
        return s[64] ? MIN64 : MAX64;
      end
      return s[63:0];
    endfunction

    function logic [31:0] scaled_coord(longint a, longint n, longint d);
      logic [127:0] p, q, lim;
      bit neg;
      p = {64'b0, magnitude(a)} * {64'b0, magnitude(n)};
      if (p == 0) return 32'd0;
      if (d == 0) begin
        clipped = 1;
        return ((a < 0) != (n < 0)) ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      neg = ((a < 0) != (n < 0)) != (d < 0);
      q = p / {64'b0, magnitude(d)};
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        clipped = 1;
        q = lim;
      end
      return neg ? 32'(-q) : q[31:0];
    endfunction

    function point_t triangulate(logic [15:0] lu, logic [15:0] lv, logic [15:0] rv);
      longint fx, fy, cx, cy, r10, r11, r12, r20, r21, r22, ty, tz;
      longint du, dv, e, n0, n1, n2, m1, m2, a, b;
      point_t res;
      fx = hi_u(calib[spt_pkg::REG_FOCAL]);   fy = lo_u(calib[spt_pkg::REG_FOCAL]);
      cx = hi_u(calib[spt_pkg::REG_PP]);      cy = lo_u(calib[spt_pkg::REG_PP]);
      r10 = lo_s(calib[spt_pkg::REG_R02_R10]);
      r11 = hi_s(calib[spt_pkg::REG_R11_R12]); r12 = lo_s(calib[spt_pkg::REG_R11_R12]);
      r20 = hi_s(calib[spt_pkg::REG_R20_R21]); r21 = lo_s(calib[spt_pkg::REG_R20_R21]);
      r22 = hi_s(calib[spt_pkg::REG_R22_TX]);
      ty = hi_s(calib[spt_pkg::REG_T_YZ]);    tz = lo_s(calib[spt_pkg::REG_T_YZ]);
      du = (longint'(lu) << 12) - cx;
      dv = (longint'(lv) << 12) - cy;
      e  = (longint'(rv) << 12) - cy;
      overflowed = 0;
      clipped = 0;
      n0 = mul_shift(du, fy, 16);
      n1 = mul_shift(dv, fx, 16);
      n2 = mul_shift(fx, fy, 16);
      m1 = add_sat(add_sat(mul_shift(r10, n0, 30), mul_shift(r11, n1, 30)),
                   mul_shift(r12, n2, 30));
      m2 = add_sat(add_sat(mul_shift(r20, n0, 30), mul_shift(r21, n1, 30)),
                   mul_shift(r22, n2, 30));
      b = sub_sat(mul_shift(e, m2, 16), mul_shift(fy, m1, 16));
      a = sub_sat(mul_shift(fy, ty, 16), mul_shift(e, tz, 16));
      res.px = scaled_coord(a, n0, b);
      res.py = scaled_coord(a, n1, b);
      res.pz = scaled_coord(a, n2, b);
      res.ok = !overflowed && !clipped && b != 0;
      return res;
    endfunction

    function void note_request(logic [15:0] lu, logic [15:0] lv, logic [15:0] rv);
      awaited.push_back(triangulate(lu, lv, rv));
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d valid=%0b",
                 $time, got.px, got.py, got.pz, got.ok);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.px !== want.px) begin
        $display("%0t: point_x expected %0d actual %0d", $time, want.px, got.px);
        errors++;
      end
      if (got.py !== want.py) begin
        $display("%0t: point_y expected %0d actual %0d", $time, want.py, got.py);
        errors++;
      end
      if (got.pz !== want.pz) begin
        $display("%0t: point_z expected %0d actual %0d", $time, want.pz, got.pz);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: depth_valid expected %0b actual %0b", $time, want.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [15:0]        left_u = 0, left_v = 0, right_u = 0, right_v = 0;
  logic               cfg_we = 0;
  logic [2:0]         cfg_addr = spt_pkg::REG_FOCAL;
  logic [63:0]        cfg_data = 0;
  logic               done;
  logic signed [31:0] point_x, point_y, point_z;
  logic               depth_valid;

  triangulation_book book = new();
  int                 quiet_lo, quiet_hi;

  stereo_point_triangulation dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) book.note_request(left_u, left_v, right_v);
    if (!rst && done) book.check_point('{point_x, point_y, point_z, depth_valid});
  end

  task automatic send_pair(logic [15:0] lu, logic [15:0] lv, logic [15:0] ru,
                           logic [15:0] rv);
    start <= 1;
    left_u <= lu; left_v <= lv; right_u <= ru; right_v <= rv;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic load_calibration(logic [63:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_addr <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      book.set_reg(i, vals[i]);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] q30(int unsigned spread);
    return 32'(32'sh4000_0000 * 0 + int'($urandom_range(2 * spread)) - int'(spread));
  endfunction

  // A plausible rig: focal lengths of 100 to 2000 pixels, near-identity
  // rotation and a baseline of a fraction of a metre.
  function automatic void plausible_rig(output logic [63:0] vals [8]);
    logic [31:0] fx, fy, cx, cy, one, tx, ty, tz;
    fx = ($urandom_range(2000, 100) << 16) | $urandom_range(16'hffff);
    fy = ($urandom_range(2000, 100) << 16) | $urandom_range(16'hffff);
    cx = ($urandom_range(700, 100) << 16) | $urandom_range(16'hffff);
    cy = ($urandom_range(500, 100) << 16) | $urandom_range(16'hffff);
    one = 32'h4000_0000;
    tx = 32'($urandom_range(65536) - 32768);
    ty = 32'($urandom_range(65536) - 32768);
    tz = 32'($urandom_range(16384) - 8192);
    vals[spt_pkg::REG_FOCAL]   = {fx, fy};
    vals[spt_pkg::REG_PP]      = {cx, cy};
    vals[spt_pkg::REG_R00_R01] = {one - $urandom_range(1 << 20), q30(1 << 24)};
    vals[spt_pkg::REG_R02_R10] = {q30(1 << 24), q30(1 << 24)};
    vals[spt_pkg::REG_R11_R12] = {one - $urandom_range(1 << 20), q30(1 << 24)};
    vals[spt_pkg::REG_R20_R21] = {q30(1 << 24), q30(1 << 24)};
    vals[spt_pkg::REG_R22_TX]  = {one - $urandom_range(1 << 20), tx};
    vals[spt_pkg::REG_T_YZ]    = {ty, tz};
  endfunction

  task automatic random_pairs(int count);
    logic [15:0] lu, lv, rv;
    for (int i = 0; i < count; i++) begin
      if ((i < quiet_lo || i > quiet_hi) && $urandom_range(99) < 12)
        pause($urandom_range(4, 1));
      if ($urandom_range(3) == 0) begin
        lu = 16'($urandom); lv = 16'($urandom); rv = 16'($urandom);
      end else begin
        // Pixels inside a normal image, rows on both views kept close.
        lu = 16'($urandom_range(1280 * 16));
        lv = 16'($urandom_range(960 * 16));
        rv = 16'(int'(lv) + $urandom_range(64) - 32);
      end
      send_pair(lu, lv, 16'($urandom), rv);
    end
  endtask

  initial begin
    logic [63:0] setup [8];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Registers still zero after reset: every denominator is zero.
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    drain();

    setup = '{64'h01f4_0000_01f4_0000, 64'h0140_0000_00f0_0000,
              64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000,
              64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000,
              64'h4000_0000_0000_0000, 64'h0000_1000_ffff_e000};
    load_calibration(setup);
    // Directed pairs: corners, the principal point, equal rows (zero
    // denominator with identity rotation) and a full-scale right row.
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_pair(16'h1400, 16'h0f00, 16'h1400, 16'h0f00);
    send_pair(16'h1400, 16'h0f00, 16'h0000, 16'h0f10);
    send_pair(16'h0000, 16'hffff, 16'hffff, 16'h0000);
    send_pair(16'hffff, 16'h0000, 16'h0000, 16'hffff);
    send_pair(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_pair(16'h1000, 16'h0800, 16'h1000, 16'h0801);
    send_pair(16'h1000, 16'h0800, 16'h1000, 16'h07ff);
    drain();

    // Extreme calibration: everything at full scale forces overflow.
    setup = '{default: 64'hffff_ffff_ffff_ffff};
    load_calibration(setup);
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_pair(16'h8000, 16'h0001, 16'h1234, 16'h7fff);
    drain();
    setup = '{64'h7fff_ffff_0000_0001, 64'h0000_0000_ffff_ffff,
              64'h8000_0000_7fff_ffff, 64'h8000_0000_7fff_ffff,
              64'h7fff_ffff_8000_0000, 64'h8000_0000_7fff_ffff,
              64'h7fff_ffff_8000_0000, 64'h7fff_ffff_8000_0000};
    load_calibration(setup);
    send_pair(16'h0000, 16'hffff, 16'h0000, 16'h0000);
    send_pair(16'hffff, 16'h0000, 16'hffff, 16'hffff);
    send_pair(16'h4000, 16'h4000, 16'h4000, 16'hc000);
    drain();

    // Random requests across several plausible rigs and one arbitrary one.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4)
        foreach (setup[i]) setup[i] = {$urandom, $urandom};
      else
        plausible_rig(setup);
      load_calibration(setup);
      quiet_lo = (phase == 1) ? 20 : -1;
      quiet_hi = (phase == 1) ? 120 : -2;
      random_pairs(145);
      drain();
    end

    repeat (60) @(posedge clk);
    if (book.errors == 0 && book.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
